### rtl/msp_pkg.sv
// Shared types, command codes and the sine table for the microstep sine PWM generator.
// No dependencies; every other file imports this package.
package msp_pkg;

  localparam int SINE_POINTS = 256;
  localparam int PHASE_BITS  = $clog2(SINE_POINTS);
  localparam int QUARTER     = SINE_POINTS / 4;
  localparam int ROM_MID     = 1600;
  localparam int PCT         = 100;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + PCT - 1) / PCT;
  localparam int PROD_W      = 18;
  localparam int QUO_W       = 11;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_HOLD  = 2'd3
  } msp_cmd_t;

  typedef struct packed {
    msp_cmd_t    cmd;
    logic        start_mode;
    logic [23:0] target;
    logic [7:0]  divider;
    logic [9:0]  rate;
    logic [6:0]  amp;
    logic        direction;
  } msp_item_t;

  typedef struct packed {
    logic                  show;
    logic [PHASE_BITS-1:0] phase;
    logic                  running;
    logic [31:0]           position;
    logic                  move_done;
  } msp_step_t;

  localparam logic [11:0] SINE_ROM [SINE_POINTS] = '{
    12'd1600, 12'd1639, 12'd1678, 12'd1718, 12'd1757, 12'd1796, 12'd1835, 12'd1873,
    12'd1912, 12'd1950, 12'd1989, 12'd2026, 12'd2064, 12'd2102, 12'd2139, 12'd2175,
    12'd2212, 12'd2248, 12'd2284, 12'd2319, 12'd2354, 12'd2388, 12'd2422, 12'd2455,
    12'd2488, 12'd2521, 12'd2553, 12'd2584, 12'd2614, 12'd2644, 12'd2674, 12'd2703,
    12'd2731, 12'd2758, 12'd2785, 12'd2811, 12'd2836, 12'd2861, 12'd2884, 12'd2907,
    12'd2930, 12'd2951, 12'd2972, 12'd2991, 12'd3010, 12'd3028, 12'd3045, 12'd3062,
    12'd3077, 12'd3092, 12'd3106, 12'd3118, 12'd3130, 12'd3141, 12'd3151, 12'd3160,
    12'd3168, 12'd3175, 12'd3182, 12'd3187, 12'd3191, 12'd3195, 12'd3197, 12'd3199,
    12'd3199, 12'd3199, 12'd3197, 12'd3195, 12'd3191, 12'd3187, 12'd3182, 12'd3175,
    12'd3168, 12'd3160, 12'd3151, 12'd3141, 12'd3130, 12'd3118, 12'd3106, 12'd3092,
    12'd3077, 12'd3062, 12'd3045, 12'd3028, 12'd3010, 12'd2991, 12'd2972, 12'd2951,
    12'd2930, 12'd2907, 12'd2884, 12'd2861, 12'd2836, 12'd2811, 12'd2785, 12'd2758,
    12'd2731, 12'd2703, 12'd2674, 12'd2644, 12'd2614, 12'd2584, 12'd2553, 12'd2521,
    12'd2488, 12'd2455, 12'd2422, 12'd2388, 12'd2354, 12'd2319, 12'd2284, 12'd2248,
    12'd2212, 12'd2175, 12'd2139, 12'd2102, 12'd2064, 12'd2026, 12'd1989, 12'd1950,
    12'd1912, 12'd1873, 12'd1835, 12'd1796, 12'd1757, 12'd1718, 12'd1678, 12'd1639,
    12'd1600, 12'd1561, 12'd1522, 12'd1482, 12'd1443, 12'd1404, 12'd1365, 12'd1327,
    12'd1288, 12'd1250, 12'd1211, 12'd1174, 12'd1136, 12'd1098, 12'd1061, 12'd1025,
    12'd988,  12'd952,  12'd916,  12'd881,  12'd846,  12'd812,  12'd778,  12'd745,
    12'd712,  12'd679,  12'd647,  12'd616,  12'd586,  12'd556,  12'd526,  12'd497,
    12'd469,  12'd442,  12'd415,  12'd389,  12'd364,  12'd339,  12'd316,  12'd293,
    12'd270,  12'd249,  12'd228,  12'd209,  12'd190,  12'd172,  12'd155,  12'd138,
    12'd123,  12'd108,  12'd94,   12'd82,   12'd70,   12'd59,   12'd49,   12'd40,
    12'd32,   12'd25,   12'd18,   12'd13,   12'd9,    12'd5,    12'd3,    12'd1,
    12'd1,    12'd1,    12'd3,    12'd5,    12'd9,    12'd13,   12'd18,   12'd25,
    12'd32,   12'd40,   12'd49,   12'd59,   12'd70,   12'd82,   12'd94,   12'd108,
    12'd123,  12'd138,  12'd155,  12'd172,  12'd190,  12'd209,  12'd228,  12'd249,
    12'd270,  12'd293,  12'd316,  12'd339,  12'd364,  12'd389,  12'd415,  12'd442,
    12'd469,  12'd497,  12'd526,  12'd556,  12'd586,  12'd616,  12'd647,  12'd679,
    12'd712,  12'd745,  12'd778,  12'd812,  12'd846,  12'd881,  12'd916,  12'd952,
    12'd988,  12'd1025, 12'd1061, 12'd1098, 12'd1136, 12'd1174, 12'd1211, 12'd1250,
    12'd1288, 12'd1327, 12'd1365, 12'd1404, 12'd1443, 12'd1482, 12'd1522, 12'd1561
  };

endpackage

### rtl/microstep_sine_pwm_generator_core.sv
// Throughput one word per cycle while out_ready does not stall the output register.
// Stage 1 holds the word and updates the motion state, stage 2 holds the amplitude
// products, the output register applies /100 and clamp. A stalled output backs up
// the stages; ready falls only once all three are full.
// Reset (synchronous, rst_n low) clears motion state and all stage valid flags.
module microstep_sine_pwm_generator_core #(
  parameter int STEP_COUNT_BITS = 24,
  parameter int PWM_CENTER      = 1600
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic               in_start_mode,
  input  logic [23:0]        in_target_steps,
  input  logic [7:0]         in_speed_divider,
  input  logic [9:0]         in_step_rate,
  input  logic [6:0]         in_amplitude,
  input  logic               in_direction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        out_pwm_a,
  output logic [11:0]        out_pwm_b,
  output logic               out_running,
  output logic signed [31:0] out_position,
  output logic               out_move_done
);
  import msp_pkg::*;

  logic               s1_v_r, mid_v_r, out_v_r;
  msp_item_t          s1_item_r;
  msp_step_t          step;
  logic               mid_running_r, mid_done_r;
  logic [31:0]        mid_position_r;
  logic [11:0]        pwm_a, pwm_b;
  logic [11:0]        out_pwm_a_r, out_pwm_b_r;
  logic               out_running_r, out_done_r;
  logic signed [31:0] out_position_r;
  logic               out_adv, mid_adv, step_en;
  logic [PHASE_BITS-1:0] phase_b;

  assign out_adv  = !out_v_r || out_ready;
  assign mid_adv  = !mid_v_r || out_adv;
  assign in_ready = !s1_v_r || mid_adv;
  assign step_en  = s1_v_r && mid_adv;
  assign phase_b  = step.phase + PHASE_BITS'(QUARTER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (mid_adv) begin
        mid_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= mid_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.cmd        <= msp_cmd_t'(in_command);
      s1_item_r.start_mode <= in_start_mode;
      s1_item_r.target     <= in_target_steps;
      s1_item_r.divider    <= in_speed_divider;
      s1_item_r.rate       <= in_step_rate;
      s1_item_r.amp        <= in_amplitude;
      s1_item_r.direction  <= in_direction;
    end
    if (step_en) begin
      mid_running_r  <= step.running;
      mid_position_r <= step.position;
      mid_done_r     <= step.move_done;
    end
    if (mid_v_r && out_adv) begin
      out_pwm_a_r    <= pwm_a;
      out_pwm_b_r    <= pwm_b;
      out_running_r  <= mid_running_r;
      out_position_r <= mid_position_r;
      out_done_r     <= mid_done_r;
    end
  end

  msp_step_ctrl #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(step_en),
    .item   (s1_item_r),
    .step   (step)
  );

  msp_scale #(
    .PWM_CENTER(PWM_CENTER)
  ) u_scale_a (
    .clk  (clk),
    .load (step_en),
    .show (step.show),
    .phase(step.phase),
    .amp  (s1_item_r.amp),
    .pwm  (pwm_a)
  );

  msp_scale #(
    .PWM_CENTER(PWM_CENTER)
  ) u_scale_b (
    .clk  (clk),
    .load (step_en),
    .show (step.show),
    .phase(phase_b),
    .amp  (s1_item_r.amp),
    .pwm  (pwm_b)
  );

  assign out_valid     = out_v_r;
  assign out_pwm_a     = out_pwm_a_r;
  assign out_pwm_b     = out_pwm_b_r;
  assign out_running   = out_running_r;
  assign out_position  = out_position_r;
  assign out_move_done = out_done_r;

`ifndef SYNTHESIS
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> !out_running)
    else $error("move_done word still reports running");

  a_idle_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running |->
      (out_pwm_a == 12'(PWM_CENTER)) && (out_pwm_b == 12'(PWM_CENTER)))
    else $error("stopped word without center compare values");

  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && mid_v_r && out_v_r && !out_ready |-> !in_ready)
    else $error("input accepted while all stages are stalled");
`endif

endmodule

### rtl/msp_step_ctrl.sv
// Motion state: prescaler, fractional phase accumulator, step counter and position.
// Depends on msp_pkg; updates once per word leaving the input stage.
module msp_step_ctrl #(
  parameter int STEP_COUNT_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  msp_pkg::msp_item_t item,
  output msp_pkg::msp_step_t step
);
  import msp_pkg::*;

  localparam int CW = STEP_COUNT_BITS;

  logic                  enabled_r, enabled_nxt;
  logic                  step_mode_r, step_mode_nxt;
  logic [CW-1:0]         step_target_r, step_target_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [7:0]            prescale_r, prescale_nxt;
  logic [5:0]            frac_r, frac_nxt;
  logic [CW-1:0]         step_cnt_r, step_cnt_nxt;
  logic [31:0]           position_r, position_nxt;

  logic [7:0]            pre_inc;
  logic                  rollover;
  logic [10:0]           acc_sum;
  logic [PHASE_BITS-1:0] carries;
  logic [CW-1:0]         cnt_inc;

  always_comb begin
    pre_inc  = prescale_r + 8'd1;
    rollover = (pre_inc >= item.divider);
    acc_sum  = {5'b0, frac_r} + {1'b0, item.rate};
    carries  = PHASE_BITS'(acc_sum[10:6]);
    cnt_inc  = step_cnt_r + CW'(1);

    enabled_nxt     = enabled_r;
    step_mode_nxt   = step_mode_r;
    step_target_nxt = step_target_r;
    phase_nxt       = phase_r;
    prescale_nxt    = prescale_r;
    frac_nxt        = frac_r;
    step_cnt_nxt    = step_cnt_r;
    position_nxt    = position_r;
    step.show       = 1'b0;
    step.move_done  = 1'b0;

    case (item.cmd)
      CMD_START: begin
        step_mode_nxt   = item.start_mode;
        step_target_nxt = item.start_mode ? CW'(item.target) : '0;
        phase_nxt       = '0;
        prescale_nxt    = '0;
        frac_nxt        = '0;
        step_cnt_nxt    = '0;
        enabled_nxt     = 1'b1;
      end
      CMD_STOP: begin
        enabled_nxt   = 1'b0;
        step_mode_nxt = 1'b0;
      end
      CMD_HOLD: begin
        step.show = enabled_r;
      end
      CMD_TICK: begin
        if (enabled_r) begin
          step.show = 1'b1;
          if (!rollover) begin
            prescale_nxt = pre_inc;
          end else begin
            prescale_nxt = '0;
            frac_nxt     = acc_sum[5:0];
            phase_nxt    = item.direction ? phase_r - carries : phase_r + carries;
            step_cnt_nxt = cnt_inc;
            position_nxt = item.direction ? position_r - 32'd1 : position_r + 32'd1;
            if (step_mode_r && (step_target_r != '0) && (cnt_inc >= step_target_r)) begin
              enabled_nxt    = 1'b0;
              step_mode_nxt  = 1'b0;
              step.show      = 1'b0;
              step.move_done = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    step.phase    = phase_nxt;
    step.running  = enabled_nxt;
    step.position = position_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= 1'b0;
      step_mode_r   <= 1'b0;
      step_target_r <= '0;
      phase_r       <= '0;
      prescale_r    <= '0;
      frac_r        <= '0;
      step_cnt_r    <= '0;
      position_r    <= '0;
    end else if (step_en) begin
      enabled_r     <= enabled_nxt;
      step_mode_r   <= step_mode_nxt;
      step_target_r <= step_target_nxt;
      phase_r       <= phase_nxt;
      prescale_r    <= prescale_nxt;
      frac_r        <= frac_nxt;
      step_cnt_r    <= step_cnt_nxt;
      position_r    <= position_nxt;
    end
  end

endmodule

### rtl/msp_scale.sv
// One winding: sine lookup, deviation times amplitude, registered, then /100 and clamp.
// Depends on msp_pkg for the sine table and reciprocal constants.
module msp_scale #(
  parameter int PWM_CENTER = 1600
) (
  input  logic                           clk,
  input  logic                           load,
  input  logic                           show,
  input  logic [msp_pkg::PHASE_BITS-1:0] phase,
  input  logic [6:0]                     amp,
  output logic [11:0]                    pwm
);
  import msp_pkg::*;

  localparam int VW = $clog2(2 * PWM_CENTER + 2048) + 1;
  localparam logic signed [VW-1:0] CENTER_V = VW'(PWM_CENTER);
  localparam logic signed [VW-1:0] TOP_V    = VW'(2 * PWM_CENTER - 1);

  logic [11:0]            point;
  logic signed [12:0]     dev;
  logic [12:0]            dev_abs;
  logic [QUO_W-1:0]       mag;
  logic [PROD_W-1:0]      prod_nxt, prod_r;
  logic                   neg_r, show_r;
  logic [PROD_W+18:0]     prod_full;
  logic [QUO_W-1:0]       quo;
  logic signed [VW-1:0]   q_abs, val;

  always_comb begin
    point    = SINE_ROM[phase];
    dev      = $signed({1'b0, point}) - 13'sd1600;
    dev_abs  = dev[12] ? 13'(-dev) : 13'(dev);
    mag      = dev_abs[QUO_W-1:0];
    prod_nxt = {7'b0, mag} * {11'b0, amp};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
      neg_r  <= dev[12];
      show_r <= show;
    end
  end

  always_comb begin
    prod_full = {19'b0, prod_r} * (PROD_W+19)'(RECIP);
    quo       = prod_full[RECIP_SHIFT +: QUO_W];
    q_abs     = $signed({{(VW-QUO_W){1'b0}}, quo});
    val       = CENTER_V + (neg_r ? -q_abs : q_abs);
    if (val < 0) begin
      val = '0;
    end else if (val > TOP_V) begin
      val = TOP_V;
    end
    pwm = show_r ? val[11:0] : 12'(PWM_CENTER);
  end

endmodule
